FILE: hw/rtl/sca_pkg.sv
// ----------------------------------------------------------------------------
// Size class buffer allocator package
// Shared constants, codes and a helper function of the buffer allocator.
// ----------------------------------------------------------------------------
package sca_pkg;

   localparam int MAX_BUFFERS_DEFAULT = 128;
   localparam int CLASS_COUNT         = 3;
   localparam int HANDLE_W_DEFAULT    = $clog2(CLASS_COUNT * MAX_BUFFERS_DEFAULT);
   localparam int WORD_W              = 32;
   localparam int BIT_W               = $clog2(WORD_W);

   localparam int OP_W     = 1;
   localparam int SIZE_W   = 16;
   localparam int STATUS_W = 2;
   localparam int CLASS_W  = 2;
   localparam int BYTES_W  = 13;
   localparam int TOTAL_W  = 32;
   localparam int COUNT_W  = 8;
   localparam int REG_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERSIZE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd3;

   localparam logic [CLASS_W-1:0] CLS_SMALL  = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_MEDIUM = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_LARGE  = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_SMALL_COUNT  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MEDIUM_COUNT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_LARGE_COUNT  = 2'd2;

   localparam logic [COUNT_W-1:0] SMALL_COUNT_RESET  = 8'd100;
   localparam logic [COUNT_W-1:0] MEDIUM_COUNT_RESET = 8'd50;
   localparam logic [COUNT_W-1:0] LARGE_COUNT_RESET  = 8'd10;

   localparam logic [SIZE_W-1:0] SMALL_BYTES  = 16'd128;
   localparam logic [SIZE_W-1:0] MEDIUM_BYTES = 16'd1024;
   localparam logic [SIZE_W-1:0] LARGE_BYTES  = 16'd4096;

   function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLASS_W-1:0] cls);
      logic [BYTES_W-1:0] bytes;
      case (cls)
         CLS_SMALL:  bytes = BYTES_W'(SMALL_BYTES);
         CLS_MEDIUM: bytes = BYTES_W'(MEDIUM_BYTES);
         CLS_LARGE:  bytes = BYTES_W'(LARGE_BYTES);
         default:    bytes = '0;
      endcase
      return bytes;
   endfunction

endpackage

FILE: hw/rtl/sca_if.sv
// ----------------------------------------------------------------------------
// Size class buffer allocator channels
// Request and response channels with a valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface sca_req_if #(
   parameter int HANDLE_W = sca_pkg::HANDLE_W_DEFAULT
);
   import sca_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [SIZE_W-1:0]   request_size;
   logic [HANDLE_W-1:0] free_handle;

   modport source (output valid, operation, request_size, free_handle, input ready);
   modport sink   (input valid, operation, request_size, free_handle, output ready);
endinterface

interface sca_rsp_if #(
   parameter int HANDLE_W = sca_pkg::HANDLE_W_DEFAULT
);
   import sca_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] granted_handle;
   logic [CLASS_W-1:0]  granted_class;
   logic [BYTES_W-1:0]  buffer_bytes;
   logic [TOTAL_W-1:0]  alloc_total;
   logic [TOTAL_W-1:0]  free_total;

   modport source (output valid, status, granted_handle, granted_class, buffer_bytes,
                   alloc_total, free_total, input ready);
   modport sink   (input valid, status, granted_handle, granted_class, buffer_bytes,
                   alloc_total, free_total, output ready);
endinterface

FILE: hw/rtl/sca_ram.sv
// ----------------------------------------------------------------------------
// Size class buffer allocator RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hw/rtl/size_class_buffer_allocator.sv
// ----------------------------------------------------------------------------
// Size class buffer allocator
// Allocates and frees buffers from three fixed-size pools and reports handles.
// ----------------------------------------------------------------------------
// The use marks of all buffers live in one RAM of 32-bit words, each class
// taking its own run of words, and a per-word valid flag makes every buffer
// free right after reset with no clearing pass. One item is handled at a
// time. An allocate scans the words of its class one per cycle through the
// single RAM read port and stops at the first word that holds a free buffer
// or at the last word of the effective count. A free reads its word and then
// writes it back with its mark cleared; an oversize request, a bad handle or
// an empty class goes straight to the finish state. A finished result sits
// in the response register while the next request is accepted.
module size_class_buffer_allocator #(
   parameter int MAX_BUFFERS_PER_CLASS = sca_pkg::MAX_BUFFERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   sca_req_if.sink                       req_if,
   sca_rsp_if.source                     rsp_if,
   input  logic                          csr_wr_en,
   input  logic [sca_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [sca_pkg::COUNT_W-1:0]   csr_wdata
);
   import sca_pkg::*;

   localparam int HANDLE_W = $clog2(CLASS_COUNT * MAX_BUFFERS_PER_CLASS);
   localparam int WPC      = (MAX_BUFFERS_PER_CLASS + WORD_W - 1) / WORD_W;
   localparam int ROWS     = CLASS_COUNT * WPC;
   localparam int ROW_W    = $clog2(ROWS);
   localparam int WW       = $clog2(WPC + 1);
   localparam logic [15:0] MAXB16 = 16'(MAX_BUFFERS_PER_CLASS);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FREE   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   function automatic logic [15:0] effective(input logic [COUNT_W-1:0] cnt);
      logic [15:0] wide;
      wide = 16'(cnt);
      return (wide > MAXB16) ? MAXB16 : wide;
   endfunction

   function automatic logic [ROW_W-1:0] base_row(input logic [CLASS_W-1:0] cls);
      return ROW_W'(32'(cls) * WPC);
   endfunction

   logic [1:0]          state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff [CLASS_COUNT];
   logic [ROWS-1:0]     row_valid_ff, row_valid_in;
   logic [TOTAL_W-1:0]  alloc_ff, alloc_in;
   logic [TOTAL_W-1:0]  free_ff, free_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [CLASS_W-1:0]  cls_ff, cls_in;
   logic [15:0]         eff_ff, eff_in;
   logic [WW-1:0]       word_ff, word_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [CLASS_W-1:0]  res_class_ff, res_class_in;
   logic [BYTES_W-1:0]  res_bytes_ff, res_bytes_in;

   logic [STATUS_W-1:0] rsp_status_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [CLASS_W-1:0]  rsp_class_ff;
   logic [BYTES_W-1:0]  rsp_bytes_ff;
   logic [TOTAL_W-1:0]  rsp_alloc_ff;
   logic [TOTAL_W-1:0]  rsp_free_ff;

   logic                req_xfer, rsp_load;
   logic                oversize, bad_handle;
   logic [CLASS_W-1:0]  alloc_cls, free_cls, sel_cls;
   logic [15:0]         handle16, free_idx, sel_eff;
   logic [ROW_W-1:0]    idle_row, rd_addr;
   logic                wr_en;
   logic [WORD_W-1:0]   wr_data, rd_data, cur_word, avail_mask, free_bits;
   logic [15:0]         remaining;
   logic                found;
   logic [BIT_W-1:0]    first_bit;

   sca_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROWS)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_if.ready = (state_ff == S_IDLE) && !reset;
   assign req_xfer     = req_if.valid && req_if.ready;
   assign rsp_load     = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      oversize = req_if.request_size > LARGE_BYTES;
      if (req_if.request_size <= SMALL_BYTES) begin
         alloc_cls = CLS_SMALL;
      end else if (req_if.request_size <= MEDIUM_BYTES) begin
         alloc_cls = CLS_MEDIUM;
      end else begin
         alloc_cls = CLS_LARGE;
      end

      handle16   = 16'(req_if.free_handle);
      bad_handle = 1'b0;
      if (handle16 < MAXB16) begin
         free_cls = CLS_SMALL;
         free_idx = handle16;
      end else if (handle16 < 16'(2 * MAX_BUFFERS_PER_CLASS)) begin
         free_cls = CLS_MEDIUM;
         free_idx = handle16 - MAXB16;
      end else if (handle16 < 16'(3 * MAX_BUFFERS_PER_CLASS)) begin
         free_cls = CLS_LARGE;
         free_idx = handle16 - 16'(2 * MAX_BUFFERS_PER_CLASS);
      end else begin
         free_cls   = CLS_SMALL;
         free_idx   = '0;
         bad_handle = 1'b1;
      end

      sel_cls = (req_if.operation == OP_ALLOC) ? alloc_cls : free_cls;
      case (sel_cls)
         CLS_SMALL:  sel_eff = effective(count_ff[0]);
         CLS_MEDIUM: sel_eff = effective(count_ff[1]);
         CLS_LARGE:  sel_eff = effective(count_ff[2]);
         default:    sel_eff = '0;
      endcase
      if (free_idx >= sel_eff) begin
         bad_handle = 1'b1;
      end

      if (req_if.operation == OP_ALLOC) begin
         idle_row = base_row(alloc_cls);
      end else begin
         idle_row = base_row(free_cls) + ROW_W'(free_idx >> BIT_W);
      end
   end

   always_comb begin
      cur_word  = row_valid_ff[row_ff] ? rd_data : '0;
      remaining = eff_ff - (16'(word_ff) << BIT_W);
      if (remaining >= 16'(WORD_W)) begin
         avail_mask = '1;
      end else begin
         avail_mask = (WORD_W'(1) << remaining[BIT_W-1:0]) - WORD_W'(1);
      end
      free_bits = ~cur_word & avail_mask;
      found     = |free_bits;
      first_bit = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            first_bit = BIT_W'(i);
         end
      end
   end

   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = idle_row;
         S_SCAN:  rd_addr = row_ff + ROW_W'(1);
         default: rd_addr = row_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      row_valid_in  = row_valid_ff;
      alloc_in      = alloc_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff;
      cls_in        = cls_ff;
      eff_in        = eff_ff;
      word_in       = word_ff;
      row_in        = row_ff;
      bit_in        = bit_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_class_in  = res_class_ff;
      res_bytes_in  = res_bytes_ff;
      wr_en         = 1'b0;
      wr_data       = cur_word;

      if (rsp_if.valid && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               res_status_in = ST_OK;
               res_handle_in = '0;
               res_class_in  = CLS_SMALL;
               res_bytes_in  = '0;
               cls_in        = sel_cls;
               eff_in        = sel_eff;
               word_in       = '0;
               row_in        = idle_row;
               bit_in        = free_idx[BIT_W-1:0];
               if (req_if.operation == OP_ALLOC) begin
                  if (oversize) begin
                     res_status_in = ST_OVERSIZE;
                     alloc_in      = alloc_ff + TOTAL_W'(1);
                     state_in      = S_FINISH;
                  end else if (sel_eff == '0) begin
                     res_status_in = ST_EXHAUSTED;
                     res_class_in  = alloc_cls;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  free_in = free_ff + TOTAL_W'(1);
                  if (bad_handle) begin
                     res_status_in = ST_BAD_HANDLE;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_FREE;
                  end
               end
            end
         end
         S_SCAN: begin
            if (found) begin
               wr_en                = 1'b1;
               wr_data              = cur_word | (WORD_W'(1) << first_bit);
               row_valid_in[row_ff] = 1'b1;
               alloc_in             = alloc_ff + TOTAL_W'(1);
               res_handle_in        = HANDLE_W'(16'(cls_ff) * MAXB16
                                      + (16'(word_ff) << BIT_W) + 16'(first_bit));
               res_class_in         = cls_ff;
               res_bytes_in         = class_bytes(cls_ff);
               state_in             = S_FINISH;
            end else if (remaining > 16'(WORD_W)) begin
               word_in = word_ff + WW'(1);
               row_in  = row_ff + ROW_W'(1);
            end else begin
               res_status_in = ST_EXHAUSTED;
               res_class_in  = cls_ff;
               state_in      = S_FINISH;
            end
         end
         S_FREE: begin
            wr_en                = 1'b1;
            wr_data              = cur_word & ~(WORD_W'(1) << bit_ff);
            row_valid_in[row_ff] = 1'b1;
            state_in             = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         alloc_ff     <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff[0]  <= SMALL_COUNT_RESET;
         count_ff[1]  <= MEDIUM_COUNT_RESET;
         count_ff[2]  <= LARGE_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         alloc_ff     <= alloc_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_SMALL_COUNT:  count_ff[0] <= csr_wdata;
               REG_MEDIUM_COUNT: count_ff[1] <= csr_wdata;
               REG_LARGE_COUNT:  count_ff[2] <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cls_ff        <= cls_in;
      eff_ff        <= eff_in;
      word_ff       <= word_in;
      row_ff        <= row_in;
      bit_ff        <= bit_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_class_ff  <= res_class_in;
      res_bytes_ff  <= res_bytes_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_handle_ff <= res_handle_ff;
         rsp_class_ff  <= res_class_ff;
         rsp_bytes_ff  <= res_bytes_ff;
         rsp_alloc_ff  <= alloc_ff;
         rsp_free_ff   <= free_ff;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.granted_handle = rsp_handle_ff;
   assign rsp_if.granted_class  = rsp_class_ff;
   assign rsp_if.buffer_bytes   = rsp_bytes_ff;
   assign rsp_if.alloc_total    = rsp_alloc_ff;
   assign rsp_if.free_total     = rsp_free_ff;

endmodule

FILE: hw/rtl/sca_checker.sv
// ----------------------------------------------------------------------------
// Size class buffer allocator checker
// Port-level assertions on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sca_checker #(
   parameter int HANDLE_W = sca_pkg::HANDLE_W_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [sca_pkg::STATUS_W-1:0] rsp_status,
   input logic [HANDLE_W-1:0]          rsp_handle,
   input logic [sca_pkg::CLASS_W-1:0]  rsp_class,
   input logic [sca_pkg::BYTES_W-1:0]  rsp_bytes,
   input logic [sca_pkg::TOTAL_W-1:0]  rsp_alloc,
   input logic [sca_pkg::TOTAL_W-1:0]  rsp_free
);
   import sca_pkg::*;

   // The allocator works on one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another one is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_handle) && $stable(rsp_alloc) && $stable(rsp_free))
      else $error("stalled response changed");

   a_no_grant_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_handle == '0 && rsp_bytes == '0)
      else $error("failed request reports a granted buffer");

   a_bytes_match_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bytes != '0 |-> rsp_bytes == class_bytes(rsp_class))
      else $error("buffer size does not match granted class");

endmodule

bind size_class_buffer_allocator sca_checker #(
   .HANDLE_W (HANDLE_W)
) u_sca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_status (rsp_if.status),
   .rsp_handle (rsp_if.granted_handle),
   .rsp_class  (rsp_if.granted_class),
   .rsp_bytes  (rsp_if.buffer_bytes),
   .rsp_alloc  (rsp_if.alloc_total),
   .rsp_free   (rsp_if.free_total)
);

FILE: tb/sca_result_checker.sv
// ----------------------------------------------------------------------------
// Buffer allocator result checker
// Follows the configuration writes and every request transfer, predicts the
// grant that each request produces and compares it field by field with the
// response transfers in order.
// ----------------------------------------------------------------------------
module sca_result_checker #(
   parameter int MAX_BUFFERS = sca_pkg::MAX_BUFFERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   sca_req_if                            req_mon,
   sca_rsp_if                            rsp_mon,
   input  logic                          csr_wr_en,
   input  logic [sca_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [sca_pkg::COUNT_W-1:0]   csr_wdata,
   output int                            fail_count,
   output int                            pending_count
);
   import sca_pkg::*;

   localparam int HANDLE_W = $clog2(CLASS_COUNT * MAX_BUFFERS);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] granted_handle;
      logic [CLASS_W-1:0]  granted_class;
      logic [BYTES_W-1:0]  buffer_bytes;
      logic [TOTAL_W-1:0]  alloc_total;
      logic [TOTAL_W-1:0]  free_total;
   } grant_type;

   logic [COUNT_W-1:0] pool_size [CLASS_COUNT];
   bit                 in_use [CLASS_COUNT][MAX_BUFFERS];
   logic [TOTAL_W-1:0] alloc_tally;
   logic [TOTAL_W-1:0] free_tally;
   grant_type          grants_due [$];

   function automatic int usable_count(input int cls);
      return (pool_size[cls] > MAX_BUFFERS) ? MAX_BUFFERS : int'(pool_size[cls]);
   endfunction

   function automatic grant_type predict_grant(input logic [OP_W-1:0]     op,
                                               input logic [SIZE_W-1:0]   size,
                                               input logic [HANDLE_W-1:0] handle);
      grant_type g;
      int        cls;
      int        idx;
      int        slot;
      g    = '0;
      slot = -1;
      if (op == OP_ALLOC) begin
         if (size > LARGE_BYTES) begin
            g.status = ST_OVERSIZE;
            alloc_tally++;
         end else begin
            cls = (size <= SMALL_BYTES) ? CLS_SMALL :
                  (size <= MEDIUM_BYTES) ? CLS_MEDIUM : CLS_LARGE;
            g.granted_class = CLASS_W'(cls);
            for (int i = usable_count(cls) - 1; i >= 0; i--) begin
               if (!in_use[cls][i]) slot = i;
            end
            if (slot < 0) begin
               g.status = ST_EXHAUSTED;
            end else begin
               in_use[cls][slot] = 1'b1;
               alloc_tally++;
               g.granted_handle = HANDLE_W'(cls * MAX_BUFFERS + slot);
               case (cls)
                  CLS_SMALL:  g.buffer_bytes = BYTES_W'(SMALL_BYTES);
                  CLS_MEDIUM: g.buffer_bytes = BYTES_W'(MEDIUM_BYTES);
                  default:    g.buffer_bytes = BYTES_W'(LARGE_BYTES);
               endcase
            end
         end
      end else begin
         cls = handle / MAX_BUFFERS;
         idx = handle % MAX_BUFFERS;
         if (cls < CLASS_COUNT && idx < usable_count(cls)) in_use[cls][idx] = 1'b0;
         else g.status = ST_BAD_HANDLE;
         free_tally++;
      end
      g.alloc_total = alloc_tally;
      g.free_total  = free_tally;
      return g;
   endfunction

   task automatic compare_field(input string field, input logic [TOTAL_W-1:0] expected,
                                input logic [TOTAL_W-1:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      grant_type due;
      if (reset) begin
         pool_size[CLS_SMALL]  = SMALL_COUNT_RESET;
         pool_size[CLS_MEDIUM] = MEDIUM_COUNT_RESET;
         pool_size[CLS_LARGE]  = LARGE_COUNT_RESET;
         foreach (in_use[c, i]) in_use[c][i] = 1'b0;
         alloc_tally = '0;
         free_tally  = '0;
         fail_count  = 0;
         grants_due.delete();
      end else begin
         if (csr_wr_en && csr_index < CLASS_COUNT) pool_size[csr_index] = csr_wdata;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (grants_due.size() == 0) begin
               $error("Response transfer arrived with no request outstanding.");
               fail_count++;
            end else begin
               due = grants_due.pop_front();
               compare_field("status", due.status, rsp_mon.status);
               compare_field("granted_handle", due.granted_handle, rsp_mon.granted_handle);
               compare_field("granted_class", due.granted_class, rsp_mon.granted_class);
               compare_field("buffer_bytes", due.buffer_bytes, rsp_mon.buffer_bytes);
               compare_field("alloc_total", due.alloc_total, rsp_mon.alloc_total);
               compare_field("free_total", due.free_total, rsp_mon.free_total);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            grants_due.push_back(predict_grant(req_mon.operation, req_mon.request_size,
                                               req_mon.free_handle));
         end
      end
      pending_count <= grants_due.size();
   end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Buffer allocator testbench
// Drives directed and random allocate and free requests through the request
// channel under several pool sizes and idle patterns, with long response
// hold-offs and full drains, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
   import sca_pkg::*;

   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int LONG_HOLD_CYCLES = 300;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [REG_IDX_W-1:0] csr_index;
   logic [COUNT_W-1:0]   csr_wdata;
   int                   fail_count;
   int                   pending_count;
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   hold_requests = 0;
   logic [COUNT_W-1:0]   pool_cfg [CLASS_COUNT];

   sca_req_if req_ch ();
   sca_rsp_if rsp_ch ();

   size_class_buffer_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sca_result_checker grant_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int holds_served;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
                            input logic [HANDLE_W_DEFAULT-1:0] handle);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.request_size <= size;
      req_ch.free_handle  <= handle;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_pool_counts(input logic [COUNT_W-1:0] s, m, l);
      logic [REG_IDX_W-1:0] ids [4];
      logic [COUNT_W-1:0]   vals [4];
      ids  = '{REG_SMALL_COUNT, REG_MEDIUM_COUNT, REG_LARGE_COUNT, REG_UNUSED};
      vals = '{s, m, l, COUNT_W'($urandom)};
      pool_cfg[CLS_SMALL]  = s;
      pool_cfg[CLS_MEDIUM] = m;
      pool_cfg[CLS_LARGE]  = l;
      for (int k = 0; k < 4; k++) begin
         csr_wr_en <= 1'b1;
         csr_index <= ids[k];
         csr_wdata <= vals[k];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random(input int alloc_pct);
      int unsigned                 boundary_sizes [8];
      logic [SIZE_W-1:0]           size;
      logic [HANDLE_W_DEFAULT-1:0] handle;
      int                          pick;
      int                          cls;
      int                          lim;
      boundary_sizes = '{0, 128, 129, 1024, 1025, 4096, 4097, 65535};
      size   = SIZE_W'($urandom);
      handle = HANDLE_W_DEFAULT'($urandom);
      pick   = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct) begin
         if (pick < 35) size = SIZE_W'($urandom_range(int'(SMALL_BYTES)));
         else if (pick < 65)
            size = SIZE_W'($urandom_range(int'(MEDIUM_BYTES), int'(SMALL_BYTES) + 1));
         else if (pick < 90)
            size = SIZE_W'($urandom_range(int'(LARGE_BYTES), int'(MEDIUM_BYTES) + 1));
         else if (pick < 95) size = SIZE_W'($urandom_range(65535, int'(LARGE_BYTES) + 1));
         else size = SIZE_W'(boundary_sizes[$urandom_range(7)]);
         send_item(OP_ALLOC, size, handle);
      end else begin
         cls = $urandom_range(CLASS_COUNT - 1);
         lim = (pool_cfg[cls] > MAX_BUFFERS_DEFAULT) ? MAX_BUFFERS_DEFAULT : pool_cfg[cls];
         if (pick < 90 && lim > 0)
            handle = HANDLE_W_DEFAULT'(cls * MAX_BUFFERS_DEFAULT + $urandom_range(lim - 1));
         send_item(OP_FREE, size, handle);
      end
   endtask

   task automatic run_phase(input logic [COUNT_W-1:0] s, m, l, input int alloc_pct,
                            input int idle_pct, input int stall_pct, input int items,
                            input int hold_at, input int pause_at);
      wait_for_drain();
      write_pool_counts(s, m, l);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < items; n++) begin
         if (n == hold_at) hold_requests++;
         if (n == pause_at) wait_for_drain();
         send_random(alloc_pct);
      end
   endtask

   initial begin
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= REG_SMALL_COUNT;
      csr_wdata           <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.operation    <= OP_ALLOC;
      req_ch.request_size <= '0;
      req_ch.free_handle  <= '0;
      pool_cfg = '{SMALL_COUNT_RESET, MEDIUM_COUNT_RESET, LARGE_COUNT_RESET};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Class boundaries, oversize requests and free corner cases at reset sizes.
      send_item(OP_ALLOC, 0, 0);
      send_item(OP_ALLOC, 128, 0);
      send_item(OP_ALLOC, 129, 0);
      send_item(OP_ALLOC, 1024, 0);
      send_item(OP_ALLOC, 1025, 0);
      send_item(OP_ALLOC, 4096, 0);
      send_item(OP_ALLOC, 4097, 0);
      send_item(OP_ALLOC, 65535, 0);
      send_item(OP_FREE, 0, 0);
      send_item(OP_FREE, 0, 0);
      send_item(OP_FREE, 0, 99);
      send_item(OP_FREE, 0, 100);
      send_item(OP_FREE, 0, 383);
      send_item(OP_FREE, 0, 511);
      send_item(OP_FREE, 0, 384);
      send_item(OP_ALLOC, 1, 0);
      send_item(OP_FREE, 0, 129);

      // Empty pools exhaust every class.
      wait_for_drain();
      write_pool_counts(0, 0, 0);
      send_item(OP_ALLOC, 0, 0);
      send_item(OP_ALLOC, 1024, 0);
      send_item(OP_ALLOC, 4096, 0);
      send_item(OP_ALLOC, 4097, 0);
      send_item(OP_FREE, 0, 0);

      // A shrunk small pool hides buffers that are still marked.
      wait_for_drain();
      write_pool_counts(1, 128, 255);
      send_item(OP_ALLOC, 0, 0);
      send_item(OP_FREE, 0, 1);

      run_phase(128, 128, 128, 90, 0, 0, 200, 20, -1);
      run_phase(16, 8, 4, 50, 53, 0, 150, -1, -1);
      run_phase(255, 200, 129, 60, 0, 53, 150, -1, 75);
      run_phase(5, 3, 2, 55, 38, 38, 150, 40, -1);
      run_phase(COUNT_W'($urandom_range(255)), COUNT_W'($urandom_range(255)),
                COUNT_W'($urandom_range(255)), 55, 0, 0, 130, -1, 60);
      run_phase(1, 0, 128, 60, 53, 53, 120, -1, -1);

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
